### rtl/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

  localparam int MAX_DIGITS = 12;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W      = (CNT_W > 4) ? CNT_W : 4;
  localparam int BUF_AW     = IDX_W + 1;
  localparam int BUF_DEPTH  = 2 ** BUF_AW;
  localparam int DIGIT_W    = 4;

  localparam logic [3:0] KEY_COMMAND = 4'd10;
  localparam logic [3:0] KEY_ZERO    = 4'd11;
  localparam logic [3:0] KEY_ENTER   = 4'd12;

  localparam logic [1:0] REG_MIN_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;

  localparam logic BANK_ENTRY = 1'b0;
  localparam logic BANK_EDIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_TAKEN       = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_INCORRECT   = 3'd2,
    ST_UNLOCKED    = 3'd3,
    ST_EDIT_START  = 3'd4,
    ST_EDIT_CANCEL = 3'd5,
    ST_TOO_SHORT   = 3'd6,
    ST_UPDATED     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_COPY,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic [3:0] min_len;
    logic [3:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [BUF_AW-1:0]  waddr;
    logic [DIGIT_W-1:0] wdata;
    logic [BUF_AW-1:0]  raddr;
  } buf_req_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [DIGIT_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } code_req_t;

  // factory code: digits 1 to 8, rest zero
  function automatic logic [DIGIT_W-1:0] code_reset_digit(input logic [IDX_W-1:0] idx);
    int i;
    i = int'(idx);
    return (i < 8) ? DIGIT_W'(i + 1) : '0;
  endfunction

endpackage

`default_nettype wire

### rtl/kcl_ram.sv
`default_nettype none

module kcl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/kcl_seq.sv
`default_nettype none

module kcl_seq
  import kcl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               key_valid,
  output logic                    key_stall,
  input  wire logic [3:0]         key_code,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [2:0]              status,
  output logic [3:0]              digits_entered,
  output logic                    in_edit_mode,
  output buf_req_t                buf_req,
  input  wire logic [DIGIT_W-1:0] buf_rdata,
  output code_req_t               code_req,
  input  wire logic [DIGIT_W-1:0] code_rdata
);

  seq_state_t            state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      entry_count, entry_count_next;
  logic [CNT_W-1:0]      edit_count, edit_count_next;
  logic [LEN_W-1:0]      stored_length, stored_length_next;
  logic                  edit_active, edit_active_next;
  status_t               status_q, status_next;
  logic [MAX_DIGITS-1:0] code_valid, code_valid_next;
  logic                  out_load;

  logic [DIGIT_W-1:0] digit;
  logic [CNT_W-1:0]   count_sel;
  logic [IDX_W-1:0]   idx_inc;
  logic [CNT_W-1:0]   idx_cnt;
  logic [DIGIT_W-1:0] code_digit;
  logic               bank;

  assign digit      = (key_code == KEY_ZERO) ? '0 : key_code;
  assign count_sel  = edit_active ? edit_count : entry_count;
  assign bank       = edit_active ? BANK_EDIT : BANK_ENTRY;
  assign idx_inc    = idx + IDX_W'(1);
  assign idx_cnt    = CNT_W'(idx) + CNT_W'(1);
  assign code_digit = code_valid[idx] ? code_rdata : code_reset_digit(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      entry_count   <= '0;
      edit_count    <= '0;
      stored_length <= LEN_W'(8);
      edit_active   <= 1'b0;
      status_q      <= ST_TAKEN;
      code_valid    <= '0;
    end else begin
      state         <= state_next;
      idx           <= idx_next;
      entry_count   <= entry_count_next;
      edit_count    <= edit_count_next;
      stored_length <= stored_length_next;
      edit_active   <= edit_active_next;
      status_q      <= status_next;
      code_valid    <= code_valid_next;
    end
  end

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    entry_count_next   = entry_count;
    edit_count_next    = edit_count;
    stored_length_next = stored_length;
    edit_active_next   = edit_active;
    status_next        = status_q;
    code_valid_next    = code_valid;
    buf_req            = '0;
    code_req           = '0;
    out_load           = 1'b0;
    key_stall          = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        buf_req.raddr  = {bank, {IDX_W{1'b0}}};
        code_req.raddr = '0;
        if (key_valid) begin
          idx_next   = '0;
          state_next = S_RESP;
          if (key_code == KEY_COMMAND) begin
            edit_active_next = !edit_active;
            edit_count_next  = '0;
            status_next      = edit_active ? ST_EDIT_CANCEL : ST_EDIT_START;
          end else if (key_code == KEY_ENTER) begin
            if (edit_active) begin
              if (LEN_W'(edit_count) < LEN_W'(cfg.min_len)) begin
                status_next = ST_TOO_SHORT;
              end else if (edit_count == '0) begin
                stored_length_next = '0;
                entry_count_next   = '0;
                edit_active_next   = 1'b0;
                status_next        = ST_UPDATED;
              end else begin
                state_next = S_COPY;
              end
            end else begin
              entry_count_next = '0;
              if (LEN_W'(entry_count) != stored_length) begin
                status_next = ST_INCORRECT;
              end else if (stored_length == '0) begin
                status_next = ST_UNLOCKED;
              end else begin
                state_next = S_CHECK;
              end
            end
          end else begin
            if ((LEN_W'(count_sel) < LEN_W'(cfg.max_len)) &&
                (count_sel < CNT_W'(MAX_DIGITS))) begin
              buf_req.we    = 1'b1;
              buf_req.waddr = {bank, IDX_W'(count_sel)};
              buf_req.wdata = digit;
              status_next   = ST_TAKEN;
              if (edit_active) begin
                edit_count_next = count_sel + CNT_W'(1);
              end else begin
                entry_count_next = count_sel + CNT_W'(1);
              end
            end else begin
              status_next = ST_TOO_LONG;
            end
          end
        end
      end
      S_CHECK: begin
        buf_req.raddr  = {BANK_ENTRY, idx_inc};
        code_req.raddr = idx_inc;
        if (buf_rdata != code_digit) begin
          status_next = ST_INCORRECT;
          state_next  = S_RESP;
        end else if (LEN_W'(idx_cnt) == stored_length) begin
          status_next = ST_UNLOCKED;
          state_next  = S_RESP;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_COPY: begin
        buf_req.raddr        = {BANK_EDIT, idx_inc};
        code_req.we          = 1'b1;
        code_req.waddr       = idx;
        code_req.wdata       = buf_rdata;
        code_valid_next[idx] = 1'b1;
        if (idx_cnt == edit_count) begin
          stored_length_next = LEN_W'(edit_count);
          edit_count_next    = '0;
          entry_count_next   = '0;
          edit_active_next   = 1'b0;
          status_next        = ST_UPDATED;
          state_next         = S_RESP;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_RESP: begin
        if (!res_valid || !res_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= status_q;
      digits_entered <= 4'(count_sel);
      in_edit_mode   <= edit_active;
    end
  end

endmodule

`default_nettype wire

### rtl/keypad_code_lock_core.sv
// channel   direction  handshake              payload
// key       in         key_valid / key_stall  key_code[3:0]
// result    out        res_valid / res_stall  status[2:0], digits_entered[3:0], in_edit_mode
// config    in         cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[3:0]
//
// digit and command keys pass through the accept cycle and the result load
// enter in unlock mode compares up to the stored length in S_CHECK, one stored digit per cycle
// enter in edit mode copies up to the new length in S_COPY, one digit copied per cycle
// each memory takes one read and at most one write per cycle
// reset is synchronous; the stored code reads as the factory code until rewritten
// a stalled result holds the sequencer, the key channel stalls meanwhile
`default_nettype none

module keypad_code_lock_core
  import kcl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       key_valid,
  output logic            key_stall,
  input  wire logic [3:0] key_code,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [2:0]      status,
  output logic [3:0]      digits_entered,
  output logic            in_edit_mode,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  cfg_t               cfg;
  buf_req_t           buf_req;
  code_req_t          code_req;
  logic [DIGIT_W-1:0] buf_rdata;
  logic [DIGIT_W-1:0] code_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_len <= 4'd8;
      cfg.max_len <= 4'd12;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_LEN: cfg.min_len <= cfg_data;
        REG_MAX_LEN: cfg.max_len <= cfg_data;
        default: ;
      endcase
    end
  end

  kcl_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .key_valid      (key_valid),
    .key_stall      (key_stall),
    .key_code       (key_code),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .digits_entered (digits_entered),
    .in_edit_mode   (in_edit_mode),
    .buf_req        (buf_req),
    .buf_rdata      (buf_rdata),
    .code_req       (code_req),
    .code_rdata     (code_rdata)
  );

  // entry and edit buffers, one bank each
  kcl_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_req.we),
    .waddr (buf_req.waddr),
    .wdata (buf_req.wdata),
    .raddr (buf_req.raddr),
    .rdata (buf_rdata)
  );

  kcl_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_code_ram (
    .clk   (clk),
    .we    (code_req.we),
    .waddr (code_req.waddr),
    .wdata (code_req.wdata),
    .raddr (code_req.raddr),
    .rdata (code_rdata)
  );

  a_one_key_at_a_time: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall |=> key_stall)
    else $error("key accepted back to back");

  a_unlock_clears_entry: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_UNLOCKED |-> !in_edit_mode && digits_entered == 4'd0)
    else $error("unlock left entry digits or edit mode");

  a_update_leaves_edit: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_UPDATED |-> !in_edit_mode && digits_entered == 4'd0)
    else $error("code update left edit mode active");

  a_edit_start_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_EDIT_START |-> in_edit_mode && digits_entered == 4'd0)
    else $error("edit start with nonempty edit buffer");

endmodule

`default_nettype wire

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 32;

  localparam logic [3:0] KEY_RAW_ZERO = 4'd0;
  localparam logic [3:0] DIGIT_KEY_LO = 4'd1;
  localparam logic [3:0] DIGIT_KEY_HI = 4'd9;
  localparam logic [3:0] KEY_SPARE_LO = 4'd13;
  localparam logic [3:0] KEY_SPARE_HI = 4'd15;

  typedef struct packed {
    status_t    st;
    logic [3:0] count;
    logic       in_edit;
  } lock_outcome_t;

  logic       clk;
  logic       rst;
  logic       key_valid;
  logic       key_stall;
  logic [3:0] key_code;
  logic       res_valid;
  logic       res_stall;
  logic [2:0] status;
  logic [3:0] digits_entered;
  logic       in_edit_mode;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  // lock state as the block should hold it
  logic [3:0] min_len;
  logic [3:0] max_len;
  logic [3:0] stored_code [MAX_DIGITS];
  logic [3:0] stored_len;
  logic [3:0] entry_buf [MAX_DIGITS];
  logic [3:0] entry_cnt;
  logic [3:0] edit_buf [MAX_DIGITS];
  logic [3:0] edit_cnt;
  logic       editing;

  lock_outcome_t pending_outcomes[$];

  int  mismatch_count;
  int  press_count;
  int  result_count;
  int  unlock_count;
  int  update_count;
  int  short_commit_count;
  int  setting_count;
  int  idle_cycles;
  bit  key_offered;
  bit  key_gaps_on;
  bit  sink_stalls;
  bit  hold_results;

  keypad_code_lock_core DUT (
    .clk            (clk),
    .rst            (rst),
    .key_valid      (key_valid),
    .key_stall      (key_stall),
    .key_code       (key_code),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .digits_entered (digits_entered),
    .in_edit_mode   (in_edit_mode),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int code_limit();
    return (max_len > MAX_DIGITS) ? MAX_DIGITS : int'(max_len);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [3:0] any_digit_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 4'($urandom_range(DIGIT_KEY_LO, DIGIT_KEY_HI));
    if (r == 7) return KEY_ZERO;
    if (r == 8) return KEY_RAW_ZERO;
    return 4'($urandom_range(KEY_SPARE_LO, KEY_SPARE_HI));
  endfunction

  // digit zero can be typed with either zero key
  function automatic logic [3:0] digit_key(input logic [3:0] d);
    if (d != 4'd0) return d;
    return ($urandom_range(0, 3) == 0) ? KEY_RAW_ZERO : KEY_ZERO;
  endfunction

  task automatic lock_clear();
    int i;
    min_len    = 4'd8;
    max_len    = 4'd12;
    stored_len = 4'd8;
    entry_cnt  = '0;
    edit_cnt   = '0;
    editing    = 1'b0;
    for (i = 0; i < MAX_DIGITS; i++) begin
      stored_code[i] = (i < 8) ? 4'(i + 1) : 4'd0;
      entry_buf[i]   = '0;
      edit_buf[i]    = '0;
    end
  endtask

  task automatic lock_press(input logic [3:0] k);
    logic [3:0]    d;
    status_t       st;
    lock_outcome_t o;
    int            i;
    d = (k == KEY_ZERO) ? 4'd0 : k;
    if (editing) begin
      if (k == KEY_COMMAND) begin
        editing  = 1'b0;
        edit_cnt = '0;
        st       = ST_EDIT_CANCEL;
      end else if (k == KEY_ENTER) begin
        if (edit_cnt < min_len) begin
          st = ST_TOO_SHORT;
        end else begin
          for (i = 0; i < edit_cnt; i++) stored_code[i] = edit_buf[i];
          stored_len = edit_cnt;
          entry_cnt  = '0;
          edit_cnt   = '0;
          editing    = 1'b0;
          st         = ST_UPDATED;
        end
      end else if (edit_cnt < code_limit()) begin
        edit_buf[edit_cnt] = d;
        edit_cnt++;
        st = ST_TAKEN;
      end else begin
        st = ST_TOO_LONG;
      end
    end else begin
      if (k == KEY_COMMAND) begin
        editing  = 1'b1;
        edit_cnt = '0;
        st       = ST_EDIT_START;
      end else if (k == KEY_ENTER) begin
        st = ST_INCORRECT;
        if (entry_cnt == stored_len) begin
          st = ST_UNLOCKED;
          for (i = 0; i < stored_len; i++) begin
            if (entry_buf[i] != stored_code[i]) st = ST_INCORRECT;
          end
        end
        entry_cnt = '0;
      end else if (entry_cnt < code_limit()) begin
        entry_buf[entry_cnt] = d;
        entry_cnt++;
        st = ST_TAKEN;
      end else begin
        st = ST_TOO_LONG;
      end
    end
    if (st == ST_UNLOCKED) unlock_count++;
    if (st == ST_UPDATED) update_count++;
    if (st == ST_TOO_SHORT) short_commit_count++;
    o.st      = st;
    o.count   = editing ? edit_cnt : entry_cnt;
    o.in_edit = editing;
    pending_outcomes.push_back(o);
  endtask

  task automatic key_release();
    if (key_offered) key_valid <= 1'b0;
    key_offered = 1'b0;
  endtask

  task automatic send_key(input logic [3:0] k);
    int gap;
    gap = key_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      key_release();
      repeat (gap) @(posedge clk);
    end
    key_valid <= 1'b1;
    key_code  <= k;
    key_offered = 1'b1;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    press_count++;
    lock_press(k);
  endtask

  task automatic wait_idle();
    key_release();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] min_v, input logic [3:0] max_v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_LEN;
    cfg_data  <= min_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_len = min_v;
    cfg_index <= REG_MAX_LEN;
    cfg_data  <= max_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_len = max_v;
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // one user interaction: an unlock attempt, a code change or stray keys
  task automatic random_session();
    int         kind;
    int         n;
    int         i;
    int         lim;
    int         r;
    logic [3:0] code_keys[$];
    kind = $urandom_range(0, 99);
    lim  = code_limit();
    if (kind < 55) begin
      if (editing) send_key(KEY_COMMAND);
      if (entry_cnt != 0) send_key(KEY_ENTER);
      if (kind < 35 || ($urandom_range(0, 1) == 1 && stored_len != 0)) begin
        for (i = 0; i < stored_len; i++) code_keys.push_back(digit_key(stored_code[i]));
        if (kind >= 35) code_keys[$urandom_range(0, stored_len - 1)] = any_digit_key();
      end else begin
        n = $urandom_range(0, lim + 1);
        for (i = 0; i < n; i++) code_keys.push_back(any_digit_key());
      end
      for (i = 0; i < code_keys.size(); i++) send_key(code_keys[i]);
      send_key(KEY_ENTER);
    end else if (kind < 85) begin
      if (editing) send_key(KEY_COMMAND);
      send_key(KEY_COMMAND);
      if (min_len <= lim && $urandom_range(0, 3) != 0) n = $urandom_range(min_len, lim);
      else n = $urandom_range(0, lim + 2);
      for (i = 0; i < n; i++) send_key(any_digit_key());
      r = $urandom_range(0, 3);
      if (r != 0) begin
        send_key(KEY_ENTER);
        if (editing && $urandom_range(0, 1) == 1) send_key(KEY_COMMAND);
      end else if ($urandom_range(0, 1) == 1) begin
        send_key(KEY_COMMAND);
      end
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_key(4'($urandom));
    end
  endtask

  task automatic test_factory_code();
    int i;
    for (i = 0; i < stored_len; i++) send_key(digit_key(stored_code[i]));
    send_key(KEY_ENTER);
    send_key(KEY_ENTER);
  endtask

  task automatic test_edit_cancel();
    send_key(DIGIT_KEY_HI);
    send_key(KEY_COMMAND);
    send_key(KEY_SPARE_HI);
    send_key(KEY_SPARE_LO);
    send_key(KEY_ZERO);
    send_key(KEY_RAW_ZERO);
    send_key(KEY_ENTER);
    send_key(KEY_COMMAND);
    send_key(KEY_ENTER);
  endtask

  task automatic test_buffer_full();
    configure(4'd8, 4'd1);
    send_key(4'd5);
    send_key(4'd5);
    send_key(KEY_ENTER);
  endtask

  task automatic test_empty_code();
    configure(4'd0, 4'd12);
    send_key(KEY_COMMAND);
    send_key(KEY_ENTER);
    send_key(KEY_ENTER);
  endtask

  task automatic test_random_phase(input logic [3:0] min_v, input logic [3:0] max_v,
                                   input int presses, input bit gaps, input bit stalls);
    int start;
    configure(min_v, max_v);
    key_gaps_on = gaps;
    sink_stalls = stalls;
    start = press_count;
    while (press_count - start < presses) random_session();
  endtask

  // results held back long enough for the key side to back up
  task automatic test_backpressure();
    int start;
    key_gaps_on  = 1'b0;
    sink_stalls  = 1'b0;
    hold_results = 1'b1;
    start = press_count;
    while (press_count - start < 40) random_session();
  endtask

  initial begin : result_sink
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_results = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    lock_outcome_t want;
    if (!rst && res_valid && !res_stall) begin
      result_count++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, status %0d digits %0d edit %0b",
                 $time, status, digits_entered, in_edit_mode);
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.st) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        end
        if (digits_entered !== want.count) begin
          mismatch_count++;
          $display("%0t: digits_entered expected %0d actual %0d",
                   $time, want.count, digits_entered);
        end
        if (in_edit_mode !== want.in_edit) begin
          mismatch_count++;
          $display("%0t: in_edit_mode expected %0b actual %0b",
                   $time, want.in_edit, in_edit_mode);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (key_valid && !key_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    key_valid <= 1'b0;
    key_code  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_cycles = 0;
    key_gaps_on = 1'b1;
    sink_stalls = 1'b1;
    lock_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_factory_code();
    test_edit_cancel();
    test_buffer_full();
    test_empty_code();
    test_random_phase(4'd8, 4'd12, 300, 1'b1, 1'b1);
    test_backpressure();
    test_random_phase(4'd4, 4'd8, 250, 1'b0, 1'b0);
    test_random_phase(4'd1, 4'd15, 250, 1'b1, 1'b1);
    test_random_phase(4'd0, 4'd13, 200, 1'b1, 1'b0);
    test_random_phase(4'd12, 4'd12, 200, 1'b0, 1'b1);
    test_random_phase(4'd15, 4'd3, 100, 1'b1, 1'b1);
    test_random_phase(4'd3, 4'd0, 80, 1'b1, 1'b1);
    test_random_phase(4'd6, 4'd10, 150, 1'b1, 1'b1);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d key presses and %0d result beats over %0d length settings",
             press_count, result_count, setting_count);
    $display("%0d unlocks, %0d code updates, %0d commits refused as too short",
             unlock_count, update_count, short_commit_count);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
